// ===== rtl/kwdt_pkg.sv =====
// Shared types, codes and constants for the keyed watchdog timer.
package kwdt_pkg;

	localparam int MAX_POWER_DEF = 20;

	localparam int PERIOD_W   = 5;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 5'd13;
	localparam logic [15:0]         CLEAR_KEY    = 16'h5743;

	localparam int BIT_ON      = 15;
	localparam int BIT_WIN     = 0;
	localparam int RUN_SHIFT   = 8;
	localparam int SLEEP_SHIFT = 1;

	// item opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// control register offset
	localparam logic [3:0] OFFSET_CTRL = 4'd0;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FUSE   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd1;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [3:0]  reg_offset;
		logic [31:0] write_data;
	} in_item_t;

	typedef struct packed {
		logic [15:0] read_data;
		logic        timeout;
		logic        disable_refused;
	} out_item_t;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== rtl/keyed_watchdog_timer.sv =====
// Top level of the keyed watchdog timer: input, configuration and result channels.
//
//  channel | signals                               | direction | purpose
//  --------+---------------------------------------+-----------+-------------------------------
//  in      | in_valid, in_ready, in_item           | sink      | tick, register write or read
//  out     | out_valid, out_ready, out_item        | source    | one result per input transaction
//  cfg     | cfg_valid, cfg_ready, cfg_index/data  | sink      | fuse lock and period registers
//
// Each input transaction is resolved combinationally: the step logic reads the
// watchdog state and updates it at the accepting edge, and the result is loaded
// into the result register at that same edge and offered from the next cycle.
// Throughput is one transaction per clock while the result register has space.
// A stalled result holds the input only while the result register stays full.
// Reset clears all state, sets the period field to 13 and empties the result
// register. Configuration writes are taken in every cycle.
module keyed_watchdog_timer import kwdt_pkg::*; #(
	parameter int MAX_POWER = MAX_POWER_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic      accept;
	logic      space;
	cfg_wr_t   cfg;
	out_item_t result;

	// accept whenever the result register can take the outcome
	assign in_ready  = space;
	assign accept    = in_valid && space;

	// register writes never stall
	assign cfg_ready = 1'b1;
	assign cfg.we    = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	// advance the watchdog state by one transaction
	kwdt_core #(
		.MAX_POWER (MAX_POWER)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept),
		.item   (in_item),
		.cfg    (cfg),
		.result (result)
	);

	// hold the result until the consumer takes it
	kwdt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.item      (result),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== rtl/kwdt_core.sv =====
// Watchdog state registers and the single-pass step logic for one transaction.
module kwdt_core import kwdt_pkg::*; #(
	parameter int MAX_POWER = MAX_POWER_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_wr_t   cfg,
	output out_item_t result
);

	localparam int CW = MAX_POWER + 1;
	localparam logic [PERIOD_W-1:0] MAX_P = PERIOD_W'(MAX_POWER);

	logic                fuse_q, fuse_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic                on_q, on_d;
	logic                win_q, win_d;
	logic [CW-1:0]       elapsed_q, elapsed_d;
	logic                stopped_q, stopped_d;
	logic                timeout_q, timeout_d;

	logic [PERIOD_W-1:0] pmin;
	logic [CW-1:0]       period_ticks;
	logic [CW-1:0]       cnt_inc;
	logic                new_on;
	logic                refused;
	logic [15:0]         rd;

	assign pmin         = (period_q > MAX_P) ? MAX_P : period_q;
	assign period_ticks = {{(CW-1){1'b0}}, 1'b1} << pmin;
	assign cnt_inc      = elapsed_q + {{(CW-1){1'b0}}, 1'b1};

	always_comb begin
		fuse_d    = fuse_q;
		period_d  = period_q;
		on_d      = on_q;
		win_d     = win_q;
		elapsed_d = elapsed_q;
		stopped_d = stopped_q;
		timeout_d = timeout_q;
		new_on    = 1'b0;
		refused   = 1'b0;
		rd        = '0;

		if (step) begin
			unique case (item.opcode)
				OP_TICK: begin
					if (on_q && !stopped_q) begin
						elapsed_d = cnt_inc;
						if (cnt_inc >= period_ticks) begin
							timeout_d = 1'b1;
							stopped_d = 1'b1;
						end
					end
				end
				OP_WRITE: begin
					if (item.reg_offset == OFFSET_CTRL) begin
						if (item.write_data[31:16] == CLEAR_KEY) begin
							elapsed_d = '0;
							stopped_d = 1'b0;
						end else begin
							new_on = item.write_data[BIT_ON];
							win_d  = item.write_data[BIT_WIN];
							if (fuse_q && !new_on) begin
								refused = 1'b1;
								new_on  = 1'b1;
							end
							on_d = new_on;
							// restart on any change of ON, or when it was off
							if (new_on != on_q || !on_q) begin
								elapsed_d = '0;
								stopped_d = 1'b0;
							end
						end
					end
				end
				OP_READ: begin
					if (item.reg_offset == OFFSET_CTRL) begin
						rd[BIT_ON]  = on_q;
						rd[BIT_WIN] = win_q;
						rd[RUN_SHIFT +: PERIOD_W]   = period_q;
						rd[SLEEP_SHIFT +: PERIOD_W] = period_q;
					end
				end
				default: begin
				end
			endcase
		end

		if (cfg.we) begin
			unique case (cfg.index)
				CFG_FUSE: begin
					fuse_d = cfg.data[0];
					// locking forces ON
					if (cfg.data[0] && !on_d) begin
						on_d      = 1'b1;
						elapsed_d = '0;
						stopped_d = 1'b0;
					end
				end
				CFG_PERIOD: begin
					period_d = cfg.data[PERIOD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuse_q    <= 1'b0;
			period_q  <= PERIOD_RESET;
			on_q      <= 1'b0;
			win_q     <= 1'b0;
			elapsed_q <= '0;
			stopped_q <= 1'b0;
			timeout_q <= 1'b0;
		end else begin
			fuse_q    <= fuse_d;
			period_q  <= period_d;
			on_q      <= on_d;
			win_q     <= win_d;
			elapsed_q <= elapsed_d;
			stopped_q <= stopped_d;
			timeout_q <= timeout_d;
		end
	end

	assign result.read_data       = rd;
	assign result.timeout         = timeout_d;
	assign result.disable_refused = refused;

endmodule

// ===== rtl/kwdt_out_reg.sv =====
// Result register with valid/ready hand-off towards the consumer.
module kwdt_out_reg import kwdt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t item,
	output logic      space,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic      valid_q;
	out_item_t item_q;

	// free when empty or when the held result leaves this cycle
	assign space = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
